// ----- rtl/sadc_pkg.sv -----
// Shared types, codes and helper functions of the SPI ADC reader with filter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sadc_pkg;

    localparam int unsigned SADC_NUM_POTS    = 14;
    localparam int unsigned SADC_NUM_MOTORS  = 8;
    localparam int unsigned SADC_CH_PER_ADC  = 7;

    localparam int SADC_IDX_W    = 4;
    localparam int SADC_VAL_W    = 16;
    localparam int SADC_SAMPLE_W = 10;
    localparam int SADC_SHIFT_W  = 3;
    localparam int SADC_ADDR_W   = 3;
    localparam int SADC_DATA_W   = 32;

    localparam logic [SADC_IDX_W:0]   SADC_NUM_POTS_W   = (SADC_IDX_W+1)'(SADC_NUM_POTS);
    localparam logic [SADC_IDX_W:0]   SADC_NUM_MOTORS_W = (SADC_IDX_W+1)'(SADC_NUM_MOTORS);

    localparam logic [1:0] MODE_POT   = 2'd0;
    localparam logic [1:0] MODE_MOTOR = 2'd1;
    localparam logic [1:0] MODE_BYTE  = 2'd2;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WAIT1 = 2'd1;
    localparam logic [1:0] PH_WAIT2 = 2'd2;
    localparam logic [1:0] PH_WAIT3 = 2'd3;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX   = 2'd1;
    localparam logic [1:0] ST_OUT_OF_TURN = 2'd2;

    localparam logic       KIND_POT   = 1'b0;
    localparam logic       KIND_MOTOR = 1'b1;

    localparam logic [1:0] SEL_NONE  = 2'd3;
    localparam logic [1:0] MOTOR_ADC = 2'd2;
    localparam logic [1:0] MAX_ADC   = 2'd2;

    localparam logic [7:0] TX_START    = 8'h01;
    localparam logic [7:0] TX_CMD_BASE = 8'h80;
    localparam logic [7:0] TX_DUMMY    = 8'h00;

    localparam logic [SADC_SHIFT_W-1:0] SHIFT_RESET = 3'd4;
    localparam logic                    REG_FILTER_SHIFT = 1'b0;

    typedef struct packed {
        logic [1:0]            mode;
        logic [SADC_IDX_W-1:0] index;
        logic [7:0]            rx_byte;
    } t_in;

    typedef struct packed {
        logic                  tx_valid;
        logic [7:0]            tx_byte;
        logic [1:0]            select_line;
        logic                  select_active;
        logic                  done_res;
        logic [1:0]            status;
        logic                  kind;
        logic [SADC_IDX_W-1:0] result_index;
        logic [SADC_VAL_W-1:0] value;
    } t_out;

    typedef struct packed {
        logic                     we;
        logic [SADC_IDX_W-1:0]    idx;
        logic [SADC_SAMPLE_W-1:0] sample;
    } t_filt_req;

    // Both helpers are constant tables over every index value.
    function automatic logic [SADC_IDX_W-1:0] pot_adc(input logic [SADC_IDX_W-1:0] idx);
        logic [SADC_IDX_W-1:0] q;
        q = '0;
        for (int i = 0; i < (1 << SADC_IDX_W); i++) begin
            if (idx == SADC_IDX_W'(i)) begin
                q = SADC_IDX_W'(i / SADC_CH_PER_ADC);
            end
        end
        return q;
    endfunction

    function automatic logic [SADC_IDX_W-1:0] pot_chan(input logic [SADC_IDX_W-1:0] idx);
        logic [SADC_IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < (1 << SADC_IDX_W); i++) begin
            if (idx == SADC_IDX_W'(i)) begin
                r = SADC_IDX_W'(i % SADC_CH_PER_ADC);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/spi_adc_reader_with_ema_filter.sv -----
// A result beat is registered (result register, or skid stage while output stalls).
// Throughput: one input beat per cycle while o_in_stall is low; the result register
// plus skid stage lets input continue for one beat while the output side stalls.
// Reset (synchronous, active low): sequencer idle, filter store cleared at once,
// filter_shift set to 4, result buffer empty.
// Depends on sadc_pkg, sadc_seq, sadc_filter and sadc_outbuf.
`default_nettype none

module spi_adc_reader_with_ema_filter (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire sadc_pkg::t_in                      i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output sadc_pkg::t_out                          o_out_data,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [sadc_pkg::SADC_ADDR_W-1:0]   paddr,
    input  wire logic [sadc_pkg::SADC_DATA_W-1:0]   pwdata,
    output logic [sadc_pkg::SADC_DATA_W-1:0]        prdata,
    output logic                                    pready
);
    import sadc_pkg::*;

    logic [SADC_SHIFT_W-1:0] r_shift;
    logic                    accept;
    logic                    full;
    t_filt_req               filt_req;
    logic [SADC_VAL_W-1:0]   filt_y;
    t_out                    result;

    assign pready     = 1'b1;
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[SADC_ADDR_W-1] == REG_FILTER_SHIFT) begin
            r_shift <= pwdata[SADC_SHIFT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[SADC_ADDR_W-1] == REG_FILTER_SHIFT) begin
            prdata = SADC_DATA_W'(r_shift);
        end
    end

    sadc_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_shift),
        .i_req   (filt_req),
        .o_y     (filt_y)
    );

    sadc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_data),
        .i_filt_y   (filt_y),
        .o_filt_req (filt_req),
        .o_result   (result)
    );

    sadc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- rtl/sadc_filter.sv -----
// Per-pot exponential filter: sample scaling, store and one update per pot read.
// Depends on sadc_pkg.
`default_nettype none

module sadc_filter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [sadc_pkg::SADC_SHIFT_W-1:0] i_shift,
    input  wire sadc_pkg::t_filt_req               i_req,
    output logic [sadc_pkg::SADC_VAL_W-1:0]        o_y
);
    import sadc_pkg::*;

    logic [SADC_VAL_W-1:0] r_store [SADC_NUM_POTS];
    logic [SADC_VAL_W-1:0] prev;
    logic [SADC_VAL_W-1:0] x;
    logic signed [SADC_VAL_W:0] diff;
    logic signed [SADC_VAL_W:0] step;

    always_comb begin
        prev = r_store[i_req.idx];
        x    = SADC_VAL_W'(i_req.sample) << i_shift;
        diff = $signed({1'b0, x}) - $signed({1'b0, prev});
        step = diff >>> i_shift;
        o_y  = prev + step[SADC_VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SADC_NUM_POTS; i++) begin
                r_store[i] <= '0;
            end
        end else if (i_req.we) begin
            r_store[i_req.idx] <= o_y;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sadc_seq.sv -----
// Read sequencer: request checks, three-byte exchange and result assembly.
// Depends on sadc_pkg; drives the filter update through a t_filt_req.
`default_nettype none

module sadc_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire sadc_pkg::t_in                 i_item,
    input  wire logic [sadc_pkg::SADC_VAL_W-1:0] i_filt_y,
    output sadc_pkg::t_filt_req                o_filt_req,
    output sadc_pkg::t_out                     o_result
);
    import sadc_pkg::*;

    logic [1:0]            r_phase, n_phase;
    logic                  r_kind, n_kind;
    logic [SADC_IDX_W-1:0] r_index, n_index;
    logic [1:0]            r_high, n_high;

    logic [1:0]            req_adc;
    logic                  req_bad;
    logic [1:0]            cur_adc;
    logic [2:0]            cur_chan;
    logic [SADC_IDX_W-1:0] pq;
    logic [SADC_IDX_W-1:0] cq;
    logic [SADC_IDX_W-1:0] cr;
    logic [SADC_SAMPLE_W-1:0] sample;

    always_comb begin
        pq = pot_adc(i_item.index);
        cq = pot_adc(r_index);
        cr = pot_chan(r_index);
        if (i_item.mode == MODE_MOTOR) begin
            req_adc = MOTOR_ADC;
            req_bad = ({1'b0, i_item.index} >= SADC_NUM_MOTORS_W) || (i_item.index > 4'd7);
        end else begin
            req_adc = pq[1:0];
            req_bad = ({1'b0, i_item.index} >= SADC_NUM_POTS_W) || (pq > 4'(MAX_ADC));
        end
        if (r_kind == KIND_MOTOR) begin
            cur_adc  = MOTOR_ADC;
            cur_chan = r_index[2:0];
        end else begin
            cur_adc  = cq[1:0];
            cur_chan = cr[2:0];
        end
        sample = {r_high, i_item.rx_byte};

        n_phase = r_phase;
        n_kind  = r_kind;
        n_index = r_index;
        n_high  = r_high;

        o_result             = '0;
        o_result.select_line = SEL_NONE;
        o_result.status      = ST_OK;

        o_filt_req.we     = 1'b0;
        o_filt_req.idx    = r_index;
        o_filt_req.sample = sample;

        if (i_accept) begin
            case (i_item.mode)
                MODE_POT, MODE_MOTOR: begin
                    if (r_phase != PH_IDLE) begin
                        o_result.status = ST_OUT_OF_TURN;
                    end else if (req_bad) begin
                        o_result.status = ST_BAD_INDEX;
                    end else begin
                        n_kind                 = i_item.mode[0];
                        n_index                = i_item.index;
                        n_phase                = PH_WAIT1;
                        o_result.tx_valid      = 1'b1;
                        o_result.tx_byte       = TX_START;
                        o_result.select_line   = req_adc;
                        o_result.select_active = 1'b1;
                    end
                end
                MODE_BYTE: begin
                    if (r_phase == PH_IDLE) begin
                        o_result.status = ST_OUT_OF_TURN;
                    end else begin
                        o_result.select_line = cur_adc;
                        case (r_phase)
                            PH_WAIT1: begin
                                o_result.tx_valid      = 1'b1;
                                o_result.tx_byte       = TX_CMD_BASE | {1'b0, cur_chan, 4'b0000};
                                o_result.select_active = 1'b1;
                                n_phase                = PH_WAIT2;
                            end
                            PH_WAIT2: begin
                                n_high                 = i_item.rx_byte[1:0];
                                o_result.tx_valid      = 1'b1;
                                o_result.tx_byte       = TX_DUMMY;
                                o_result.select_active = 1'b1;
                                n_phase                = PH_WAIT3;
                            end
                            default: begin
                                o_result.done_res     = 1'b1;
                                o_result.kind         = r_kind;
                                o_result.result_index = r_index;
                                if (r_kind == KIND_POT &&
                                    {1'b0, r_index} < SADC_NUM_POTS_W) begin
                                    o_filt_req.we  = 1'b1;
                                    o_result.value = i_filt_y;
                                end else begin
                                    o_result.value = SADC_VAL_W'(sample);
                                end
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    o_result.status = ST_OUT_OF_TURN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= KIND_POT;
            r_index <= '0;
            r_high  <= '0;
        end else begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_index <= n_index;
            r_high  <= n_high;
        end
    end

    a_pot_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE && r_kind == KIND_POT) |-> ({1'b0, r_index} < SADC_NUM_POTS_W))
        else $error("pot read in progress with an index outside the filter store");

    a_motor_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE && r_kind == KIND_MOTOR) |->
        ({1'b0, r_index} < SADC_NUM_MOTORS_W))
        else $error("motor read in progress with a bad index");

endmodule

`default_nettype wire

// ----- rtl/sadc_outbuf.sv -----
// Result register with a skid stage, so a new beat can enter while one waits.
// Depends on sadc_pkg for the result type.
`default_nettype none

module sadc_outbuf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sadc_pkg::t_out i_data,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_stall,
    output sadc_pkg::t_out      o_data
);
    import sadc_pkg::*;

    logic r_main_valid;
    logic r_skid_valid;
    t_out r_main;
    t_out r_skid;
    logic take;

    assign take    = r_main_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid stage holds a beat while the result register is empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("beat pushed into a full result buffer");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_main_valid && !r_skid_valid))
        else $error("skid beat did not move to the result register");

endmodule

`default_nettype wire

// ----- tb/spi_adc_reader_with_ema_filter_tb.sv -----
// Self-checking testbench for spi_adc_reader_with_ema_filter: queued SPI events drive
// the input port and a local predictor of the sequencer and pot filter checks each result.
// Depends on sadc_pkg and the block's RTL only.
module spi_adc_reader_with_ema_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sadc_pkg::*;

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;
    localparam int CHUNK_BEATS = 265;
    localparam logic [SADC_SHIFT_W-1:0] SHIFT_PLAN [5] = '{3'd0, 3'd6, 3'd7, 3'd2, 3'd5};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    t_in                    in_data = '0;
    logic                   out_stall = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    t_out                   o_out_data;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [SADC_ADDR_W-1:0] paddr = '0;
    logic [SADC_DATA_W-1:0] pwdata = '0;
    logic [SADC_DATA_W-1:0] prdata;
    logic                   pready;

    t_in  spi_events [$];
    t_out expected_responses [$];
    int   mismatch_count = 0;
    int   send_idle_pct = 6;
    int   recv_idle_pct = 76;
    int   hold_requests = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    // Predicted state of the sequencer and the pot filter.
    logic [1:0]            seq_phase = PH_IDLE;
    logic                  cur_kind = KIND_POT;
    logic [SADC_IDX_W-1:0] cur_index = '0;
    logic [1:0]            cur_high = '0;
    logic [SADC_SHIFT_W-1:0] ema_shift = SHIFT_RESET;
    logic [SADC_VAL_W-1:0] ema_store [SADC_NUM_POTS] = '{default: '0};

    spi_adc_reader_with_ema_filter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [1:0] target_adc(input logic kind, input logic [SADC_IDX_W-1:0] idx);
        if (kind == KIND_MOTOR) begin
            return MOTOR_ADC;
        end
        return 2'(idx / SADC_CH_PER_ADC);
    endfunction

    function automatic logic [SADC_VAL_W-1:0] ema_step(input logic [SADC_IDX_W-1:0] pot,
                                                      input logic [SADC_SAMPLE_W-1:0] sample);
        logic [31:0]           wide;
        logic [SADC_VAL_W-1:0] scaled;
        int                    diff;
        logic [SADC_VAL_W-1:0] y;
        wide = 32'(sample) << ema_shift;
        scaled = wide[SADC_VAL_W-1:0];
        diff = int'(scaled) - int'(ema_store[pot]);
        diff = diff >>> ema_shift;
        y = SADC_VAL_W'(int'(ema_store[pot]) + diff);
        ema_store[pot] = y;
        return y;
    endfunction

    function automatic t_out sadc_response(input t_in beat);
        t_out                     r;
        logic [SADC_IDX_W-1:0]    chan;
        logic [SADC_SAMPLE_W-1:0] sample;
        r = '0;
        r.select_line = SEL_NONE;
        if (beat.mode == MODE_POT || beat.mode == MODE_MOTOR) begin
            if (seq_phase != PH_IDLE) begin
                r.status = ST_OUT_OF_TURN;
            end else if ((beat.mode == MODE_POT && beat.index >= SADC_NUM_POTS) ||
                         (beat.mode == MODE_MOTOR && beat.index >= SADC_NUM_MOTORS)) begin
                r.status = ST_BAD_INDEX;
            end else begin
                cur_kind = (beat.mode == MODE_MOTOR) ? KIND_MOTOR : KIND_POT;
                cur_index = beat.index;
                seq_phase = PH_WAIT1;
                r.tx_valid = 1'b1;
                r.tx_byte = TX_START;
                r.select_line = target_adc(cur_kind, cur_index);
                r.select_active = 1'b1;
            end
            return r;
        end
        if (beat.mode == MODE_RESERVED || seq_phase == PH_IDLE) begin
            r.status = ST_OUT_OF_TURN;
            return r;
        end
        r.select_line = target_adc(cur_kind, cur_index);
        case (seq_phase)
            PH_WAIT1: begin
                if (cur_kind == KIND_MOTOR) begin
                    chan = cur_index;
                end else begin
                    chan = SADC_IDX_W'(cur_index % SADC_CH_PER_ADC);
                end
                r.tx_valid = 1'b1;
                r.tx_byte = TX_CMD_BASE | {1'b0, chan[2:0], 4'b0000};
                r.select_active = 1'b1;
                seq_phase = PH_WAIT2;
            end
            PH_WAIT2: begin
                cur_high = beat.rx_byte[1:0];
                r.tx_valid = 1'b1;
                r.tx_byte = TX_DUMMY;
                r.select_active = 1'b1;
                seq_phase = PH_WAIT3;
            end
            default: begin
                sample = {cur_high, beat.rx_byte};
                r.done_res = 1'b1;
                r.kind = cur_kind;
                r.result_index = cur_index;
                if (cur_kind == KIND_POT) begin
                    r.value = ema_step(cur_index, sample);
                end else begin
                    r.value = SADC_VAL_W'(sample);
                end
                seq_phase = PH_IDLE;
            end
        endcase
        return r;
    endfunction

    task automatic flag_field(input string field, input logic [63:0] want, input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch on %s: expected %0h, got %0h at %0t", field, want, got, $time);
        end
    endtask

    task automatic push_beat(input logic [1:0] mode, input logic [SADC_IDX_W-1:0] idx,
                             input logic [7:0] rx);
        spi_events.push_back(t_in'{mode: mode, index: idx, rx_byte: rx});
    endtask

    task automatic write_filter_shift(input logic [SADC_SHIFT_W-1:0] shift);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SADC_ADDR_W'(4 * REG_FILTER_SHIFT);
        pwdata <= SADC_DATA_W'(shift);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        ema_shift = shift;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        while ((spi_events.size() != 0 || in_valid || expected_responses.size() != 0) &&
               waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT) begin
            flag_field("results still outstanding", 0, expected_responses.size());
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_random_traffic(input int n);
        int         queued;
        int         noise_slot;
        logic [1:0] mode;
        queued = 0;
        while (queued < n) begin
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(1) == 1) begin
                    push_beat(MODE_MOTOR, 4'($urandom_range(SADC_NUM_MOTORS - 1)),
                              8'($urandom_range(255)));
                end else begin
                    push_beat(MODE_POT, 4'($urandom_range(SADC_NUM_POTS - 1)),
                              8'($urandom_range(255)));
                end
                noise_slot = ($urandom_range(9) == 0) ? $urandom_range(2) : -1;
                for (int b = 0; b < 3; b++) begin
                    if (b == noise_slot) begin
                        mode = ($urandom_range(1) == 1) ? MODE_RESERVED : 2'($urandom_range(1));
                        push_beat(mode, 4'($urandom_range(15)), 8'($urandom_range(255)));
                    end
                    push_beat(MODE_BYTE, 4'($urandom_range(15)), 8'($urandom_range(255)));
                end
                queued += 4;
            end else begin
                case ($urandom_range(3))
                    0: push_beat(MODE_BYTE, 4'($urandom_range(15)), 8'($urandom_range(255)));
                    1: push_beat(MODE_POT, 4'($urandom_range(15, SADC_NUM_POTS)),
                                 8'($urandom_range(255)));
                    2: push_beat(MODE_MOTOR, 4'($urandom_range(15, SADC_NUM_MOTORS)),
                                 8'($urandom_range(255)));
                    default: push_beat(MODE_RESERVED, 4'($urandom_range(15)),
                                       8'($urandom_range(255)));
                endcase
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_responses.push_back(sadc_response(in_data));
            end
            if (!in_valid || !o_in_stall) begin
                if (spi_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_data <= spi_events.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_responses.size() == 0) begin
                flag_field("unexpected result beat", 0, o_out_data);
            end else begin
                want = expected_responses.pop_front();
                if (o_out_data.tx_valid !== want.tx_valid)
                    flag_field("tx_valid", want.tx_valid, o_out_data.tx_valid);
                if (o_out_data.tx_byte !== want.tx_byte)
                    flag_field("tx_byte", want.tx_byte, o_out_data.tx_byte);
                if (o_out_data.select_line !== want.select_line)
                    flag_field("select_line", want.select_line, o_out_data.select_line);
                if (o_out_data.select_active !== want.select_active)
                    flag_field("select_active", want.select_active, o_out_data.select_active);
                if (o_out_data.done_res !== want.done_res)
                    flag_field("done_res", want.done_res, o_out_data.done_res);
                if (o_out_data.status !== want.status)
                    flag_field("status", want.status, o_out_data.status);
                if (o_out_data.kind !== want.kind)
                    flag_field("kind", want.kind, o_out_data.kind);
                if (o_out_data.result_index !== want.result_index)
                    flag_field("result_index", want.result_index, o_out_data.result_index);
                if (o_out_data.value !== want.value)
                    flag_field("value", want.value, o_out_data.value);
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out-of-turn bytes, the reserved mode and bad indices while idle.
        push_beat(MODE_BYTE, 4'd15, 8'hFF);
        push_beat(MODE_RESERVED, 4'd15, 8'hFF);
        push_beat(MODE_POT, 4'd14, 8'h00);
        push_beat(MODE_POT, 4'd15, 8'hFF);
        push_beat(MODE_MOTOR, 4'd8, 8'h00);
        push_beat(MODE_MOTOR, 4'd15, 8'hFF);
        // Full-scale sample on the first pot.
        push_beat(MODE_POT, 4'd0, 8'h00);
        push_beat(MODE_BYTE, 4'd0, 8'h00);
        push_beat(MODE_BYTE, 4'd5, 8'hFF);
        push_beat(MODE_BYTE, 4'd10, 8'hFF);
        // Last pot with a request and a reserved beat arriving mid-read.
        push_beat(MODE_POT, 4'd13, 8'h5A);
        push_beat(MODE_MOTOR, 4'd0, 8'hA5);
        push_beat(MODE_BYTE, 4'd3, 8'h00);
        push_beat(MODE_BYTE, 4'd12, 8'h00);
        push_beat(MODE_RESERVED, 4'd0, 8'h00);
        push_beat(MODE_BYTE, 4'd7, 8'h00);
        // Highest motor channel.
        push_beat(MODE_MOTOR, 4'd7, 8'h00);
        push_beat(MODE_BYTE, 4'd0, 8'h00);
        push_beat(MODE_BYTE, 4'd0, 8'hFE);
        push_beat(MODE_BYTE, 4'd0, 8'hA5);
        // First pot of the second converter.
        push_beat(MODE_POT, 4'd7, 8'hC3);
        push_beat(MODE_BYTE, 4'd9, 8'h3C);
        push_beat(MODE_BYTE, 4'd6, 8'h01);
        push_beat(MODE_BYTE, 4'd1, 8'h80);
        wait_drained();

        for (int c = 0; c < 5; c++) begin
            if (c == 2) begin
                send_idle_pct = 76;
                recv_idle_pct = 6;
            end
            if (c == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_filter_shift(SHIFT_PLAN[c]);
            queue_random_traffic(CHUNK_BEATS);
            if (c == 4) begin
                hold_requests <= hold_requests + 1;
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- spi_adc_reader_with_ema_filter.f -----
rtl/sadc_pkg.sv
rtl/sadc_filter.sv
rtl/sadc_seq.sv
rtl/sadc_outbuf.sv
rtl/spi_adc_reader_with_ema_filter.sv
tb/spi_adc_reader_with_ema_filter_tb.sv
